// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// constants, types and tables shared by the quaternion to euler blocks
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int ISQRT_STEPS  = 32;
   localparam int LIFT_SHIFT   = 20;
   localparam int CORDIC_W     = 57;
   localparam int ANGLE_W      = 34;
   localparam int OUT_W        = 16;

   localparam logic signed [ANGLE_W-1:0] PI_Q29      = ANGLE_W'(64'sd1686629713);
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q29 = ANGLE_W'(64'sd843314856);
   localparam logic signed [30:0]        DEG_K       = 31'sd961263669;

   localparam logic [ANGLE_W-1:0] ATAN_HEAD [10] = '{
      ANGLE_W'(421657428), ANGLE_W'(248918915), ANGLE_W'(131521918),
      ANGLE_W'(66762579),  ANGLE_W'(33510843),  ANGLE_W'(16771758),
      ANGLE_W'(8387925),   ANGLE_W'(4194219),   ANGLE_W'(2097141),
      ANGLE_W'(1048575)
   };

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ANGLE_W-1:0]  z;
   } cordic_in_type;

   typedef struct packed {
      logic invalid;
      logic yaw_zero;
      logic roll_zero;
      logic pitch_zero;
      logic pitch_sat;
      logic pitch_neg;
   } flags_type;

   function automatic logic signed [ANGLE_W-1:0] atan_q29(input int i);
      logic signed [ANGLE_W-1:0] r;
      if (i < 10) begin
         r = $signed(ATAN_HEAD[i]);
      end else if (i < 30) begin
         r = ANGLE_W'(64'sd1 <<< (29 - i));
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

// ===== rtl/q2e_if.sv =====
// ----------------------------------------------------------------------------
// q2e_req_if / q2e_rsp_if
// valid/ready channels carrying a quaternion item and an euler angle item
// ----------------------------------------------------------------------------
interface q2e_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [q2e_pkg::SAMPLE_WIDTH-1:0] q_real;
   logic signed [q2e_pkg::SAMPLE_WIDTH-1:0] q_i;
   logic signed [q2e_pkg::SAMPLE_WIDTH-1:0] q_j;
   logic signed [q2e_pkg::SAMPLE_WIDTH-1:0] q_k;

   modport source (output valid, q_real, q_i, q_j, q_k, input ready);
   modport sink   (input valid, q_real, q_i, q_j, q_k, output ready);
endinterface

interface q2e_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [q2e_pkg::OUT_W-1:0]  yaw_angle;
   logic signed [q2e_pkg::OUT_W-1:0]  pitch_angle;
   logic signed [q2e_pkg::OUT_W-1:0]  roll_angle;
   logic                              invalid;

   modport source (output valid, yaw_angle, pitch_angle, roll_angle, invalid, input ready);
   modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, invalid, output ready);
endinterface

// ===== rtl/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic, one iteration per register stage
// ----------------------------------------------------------------------------
module q2e_cordic (
   input  logic                                   clock,
   input  logic                                   enable,
   input  q2e_pkg::cordic_in_type                 cin,
   output logic signed [q2e_pkg::ANGLE_W-1:0]     z_out
);

   q2e_pkg::cordic_in_type stage_in [q2e_pkg::CORDIC_STEPS];
   q2e_pkg::cordic_in_type stage_in_w [q2e_pkg::CORDIC_STEPS];
   q2e_pkg::cordic_in_type stage_ff [q2e_pkg::CORDIC_STEPS];

   for (genvar i = 0; i < q2e_pkg::CORDIC_STEPS; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign stage_in[i] = cin;
      end else begin : g_next
         assign stage_in[i] = stage_ff[i-1];
      end

      always_comb begin
         logic signed [q2e_pkg::CORDIC_W-1:0] dx;
         logic signed [q2e_pkg::CORDIC_W-1:0] dy;
         dx = stage_in[i].y >>> i;
         dy = stage_in[i].x >>> i;
         if (stage_in[i].y < 0) begin
            stage_in_w[i].x = stage_in[i].x - dx;
            stage_in_w[i].y = stage_in[i].y + dy;
            stage_in_w[i].z = stage_in[i].z - q2e_pkg::atan_q29(i);
         end else begin
            stage_in_w[i].x = stage_in[i].x + dx;
            stage_in_w[i].y = stage_in[i].y - dy;
            stage_in_w[i].z = stage_in[i].z + q2e_pkg::atan_q29(i);
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            stage_ff[i] <= stage_in_w[i];
         end
      end
   end

   assign z_out = stage_ff[q2e_pkg::CORDIC_STEPS-1].z;

endmodule

// ===== rtl/quaternion_to_euler.sv =====
// the pitch path sets the pipeline depth:
//   products, sums, squared-root operand, 32-stage integer square root, cordic
// throughput: one item per cycle; the whole pipeline holds while the result stalls
// reset: synchronous, clears all valid bits and sets unit_ff to radians
// ----------------------------------------------------------------------------
// quaternion_to_euler
// zyx euler angles from a q1.14 quaternion, radians q3.12 or degrees q9.6
// ----------------------------------------------------------------------------
module quaternion_to_euler (
   input  logic         clock,
   input  logic         reset,
   q2e_req_if.sink      req,
   q2e_rsp_if.source    rsp,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   localparam int LAT    = q2e_pkg::ISQRT_STEPS + q2e_pkg::CORDIC_STEPS + 9;
   localparam int PY_DLY = q2e_pkg::ISQRT_STEPS + 3;
   localparam int YZ_DLY = q2e_pkg::ISQRT_STEPS + 2;
   localparam int FL_DLY = q2e_pkg::ISQRT_STEPS + q2e_pkg::CORDIC_STEPS + 3;
   localparam int AW     = q2e_pkg::ANGLE_W;
   localparam int CW     = q2e_pkg::CORDIC_W;
   localparam int SW     = q2e_pkg::SAMPLE_WIDTH;
   localparam int DN     = (SW > 16) ? SW - 16 : 0;
   localparam int UP     = (SW < 16) ? 16 - SW : 0;

   // align a component to 16 bits, floor on the way down
   function automatic logic signed [15:0] align_in(input logic signed [SW-1:0] v);
      logic signed [SW+15:0] w;
      w = {{16{v[SW-1]}}, v};
      w = w >>> DN;
      w = w <<< UP;
      return w[15:0];
   endfunction

   function automatic q2e_pkg::cordic_in_type prep(input logic signed [33:0] y,
                                                   input logic signed [32:0] x);
      q2e_pkg::cordic_in_type r;
      logic signed [CW-1:0] xl;
      logic signed [CW-1:0] yl;
      xl = CW'(x);
      yl = CW'(y);
      r.z = '0;
      if (x < 0) begin
         r.z = (y >= 0) ? q2e_pkg::PI_Q29 : -q2e_pkg::PI_Q29;
         xl = -xl;
         yl = -yl;
      end
      r.x = xl <<< q2e_pkg::LIFT_SHIFT;
      r.y = yl <<< q2e_pkg::LIFT_SHIFT;
      return r;
   endfunction

   logic            adv;
   logic [LAT-1:0]  vld_ff;
   logic            unit_ff;

   // stage 0: capture
   logic signed [15:0] qr_ff, qi_ff, qj_ff, qk_ff;
   // stage 1: products
   logic [30:0]        sr_ff, si_ff, sj_ff, sk_ff;
   logic signed [31:0] pij_ff, pkr_ff, pjk_ff, pir_ff, pjr_ff, pik_ff;
   // stage 2: sums
   logic [32:0]        n_ff;
   logic signed [33:0] yy_ff, ry_ff;
   logic signed [32:0] yx_ff, rx_ff, p_ff;
   // stage 3
   q2e_pkg::cordic_in_type yaw_c_ff, roll_c_ff, pitch_c;
   logic [32:0]        a_ff, b_ff;
   logic signed [33:0] py_dl_ff [PY_DLY];
   q2e_pkg::flags_type fl_dl_ff [FL_DLY];
   q2e_pkg::flags_type fl_in;
   // stages 4..5
   logic [49:0]        pp_lo_ff;
   logic [48:0]        pp_hi_ff;
   logic [63:0]        rad_ff;
   // square root
   logic [63:0]        sq_v_ff [q2e_pkg::ISQRT_STEPS];
   logic [63:0]        sq_r_ff [q2e_pkg::ISQRT_STEPS];
   // cordic outputs and alignment
   logic signed [AW-1:0] yaw_z, roll_z, pitch_z;
   logic signed [AW-1:0] yz_dl_ff [YZ_DLY];
   logic signed [AW-1:0] rz_dl_ff [YZ_DLY];
   // output stages
   logic signed [AW-1:0] ang_ff [3];
   logic signed [AW-1:0] ang2_ff [3];
   logic signed [63:0]   prod_ff [3];
   logic                 inv1_ff, inv2_ff;
   logic signed [15:0]   out_in [3];
   logic signed [15:0]   out_ff [3];
   logic                 inv_out_ff;

   assign adv       = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         unit_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], req.valid};
         end
         if (csr_wr_en) begin
            unit_ff <= csr_wr_data;
         end
      end
   end

   // front end: special-case flags, products, sums, operand prep
   always_comb begin
      logic [33:0] n_w, tw_w;
      n_w  = {1'b0, n_ff};
      tw_w = (p_ff < 0) ? 34'(-p_ff) : 34'(p_ff);
      tw_w = tw_w << 1;
      fl_in.invalid    = (n_ff == '0);
      fl_in.yaw_zero   = (yy_ff == '0) && (yx_ff == '0);
      fl_in.roll_zero  = (ry_ff == '0) && (rx_ff == '0);
      fl_in.pitch_zero = (p_ff == '0);
      fl_in.pitch_sat  = (tw_w >= n_w);
      fl_in.pitch_neg  = p_ff[32];
   end

   always_ff @(posedge clock) begin
      logic [33:0] n_w, tw_w;
      if (adv) begin
         qr_ff <= align_in(req.q_real);
         qi_ff <= align_in(req.q_i);
         qj_ff <= align_in(req.q_j);
         qk_ff <= align_in(req.q_k);

         sr_ff  <= 31'(qr_ff * qr_ff);
         si_ff  <= 31'(qi_ff * qi_ff);
         sj_ff  <= 31'(qj_ff * qj_ff);
         sk_ff  <= 31'(qk_ff * qk_ff);
         pij_ff <= 32'(qi_ff * qj_ff);
         pkr_ff <= 32'(qk_ff * qr_ff);
         pjk_ff <= 32'(qj_ff * qk_ff);
         pir_ff <= 32'(qi_ff * qr_ff);
         pjr_ff <= 32'(qj_ff * qr_ff);
         pik_ff <= 32'(qi_ff * qk_ff);

         n_ff  <= 33'(sr_ff) + 33'(si_ff) + 33'(sj_ff) + 33'(sk_ff);
         yy_ff <= (34'(pij_ff) + 34'(pkr_ff)) <<< 1;
         ry_ff <= (34'(pjk_ff) + 34'(pir_ff)) <<< 1;
         yx_ff <= $signed(33'(si_ff)) - $signed(33'(sj_ff))
                  - $signed(33'(sk_ff)) + $signed(33'(sr_ff));
         rx_ff <= -$signed(33'(si_ff)) - $signed(33'(sj_ff))
                  + $signed(33'(sk_ff)) + $signed(33'(sr_ff));
         p_ff  <= 33'(pjr_ff) - 33'(pik_ff);

         yaw_c_ff  <= prep(yy_ff, yx_ff);
         roll_c_ff <= prep(ry_ff, rx_ff);
         n_w  = {1'b0, n_ff};
         tw_w = (p_ff < 0) ? 34'(-p_ff) : 34'(p_ff);
         tw_w = tw_w << 1;
         a_ff <= 33'(n_w - tw_w);
         b_ff <= 33'(n_w + tw_w);

         pp_lo_ff <= 50'(a_ff * b_ff[16:0]);
         pp_hi_ff <= 49'(a_ff * b_ff[32:17]);
         rad_ff   <= 64'(pp_lo_ff) + (64'(pp_hi_ff) << 17);

         py_dl_ff[0] <= 34'(p_ff) <<< 1;
         for (int j = 1; j < PY_DLY; j++) begin
            py_dl_ff[j] <= py_dl_ff[j-1];
         end
         fl_dl_ff[0] <= fl_in;
         for (int j = 1; j < FL_DLY; j++) begin
            fl_dl_ff[j] <= fl_dl_ff[j-1];
         end
      end
   end

   // integer square root, one result bit per stage
   for (genvar k = 0; k < q2e_pkg::ISQRT_STEPS; k++) begin : g_sqrt
      logic [63:0] v_w, r_w, one_w;
      if (k == 0) begin : g_first
         assign v_w = rad_ff;
         assign r_w = '0;
      end else begin : g_next
         assign v_w = sq_v_ff[k-1];
         assign r_w = sq_r_ff[k-1];
      end
      assign one_w = 64'(1) << (62 - 2 * k);
      always_ff @(posedge clock) begin
         if (adv) begin
            if (v_w >= r_w + one_w) begin
               sq_v_ff[k] <= v_w - (r_w + one_w);
               sq_r_ff[k] <= (r_w >> 1) + one_w;
            end else begin
               sq_v_ff[k] <= v_w;
               sq_r_ff[k] <= r_w >> 1;
            end
         end
      end
   end

   assign pitch_c.x = CW'({1'b0, sq_r_ff[q2e_pkg::ISQRT_STEPS-1][31:0]}) <<< q2e_pkg::LIFT_SHIFT;
   assign pitch_c.y = CW'(py_dl_ff[PY_DLY-1]) <<< q2e_pkg::LIFT_SHIFT;
   assign pitch_c.z = '0;

   q2e_cordic u_yaw   (.clock(clock), .enable(adv), .cin(yaw_c_ff),  .z_out(yaw_z));
   q2e_cordic u_roll  (.clock(clock), .enable(adv), .cin(roll_c_ff), .z_out(roll_z));
   q2e_cordic u_pitch (.clock(clock), .enable(adv), .cin(pitch_c),   .z_out(pitch_z));

   // back end: special cases, unit scaling, rounding
   always_comb begin
      logic [34:0] rsum;
      logic [63:0] dsum;
      for (int m = 0; m < 3; m++) begin
         rsum = 35'(ang2_ff[m]) + (35'(1) << 16);
         dsum = 64'(prod_ff[m]) + (64'(1) << 46);
         out_in[m] = unit_ff ? dsum[62:47] : rsum[32:17];
      end
   end

   always_ff @(posedge clock) begin
      q2e_pkg::flags_type f;
      if (adv) begin
         yz_dl_ff[0] <= yaw_z;
         rz_dl_ff[0] <= roll_z;
         for (int j = 1; j < YZ_DLY; j++) begin
            yz_dl_ff[j] <= yz_dl_ff[j-1];
            rz_dl_ff[j] <= rz_dl_ff[j-1];
         end

         f = fl_dl_ff[FL_DLY-1];
         ang_ff[0] <= (f.invalid || f.yaw_zero) ? '0 : yz_dl_ff[YZ_DLY-1];
         ang_ff[2] <= (f.invalid || f.roll_zero) ? '0 : rz_dl_ff[YZ_DLY-1];
         if (f.invalid || f.pitch_zero) begin
            ang_ff[1] <= '0;
         end else if (f.pitch_sat) begin
            ang_ff[1] <= f.pitch_neg ? -q2e_pkg::HALF_PI_Q29 : q2e_pkg::HALF_PI_Q29;
         end else begin
            ang_ff[1] <= pitch_z;
         end
         inv1_ff <= f.invalid;

         for (int m = 0; m < 3; m++) begin
            prod_ff[m] <= 64'(ang_ff[m] * q2e_pkg::DEG_K);
            ang2_ff[m] <= ang_ff[m];
            out_ff[m]  <= out_in[m];
         end
         inv2_ff    <= inv1_ff;
         inv_out_ff <= inv2_ff;
      end
   end

   assign rsp.valid       = vld_ff[LAT-1];
   assign rsp.yaw_angle   = out_ff[0];
   assign rsp.pitch_angle = out_ff[1];
   assign rsp.roll_angle  = out_ff[2];
   assign rsp.invalid     = inv_out_ff;

endmodule

// ===== rtl/q2e_checker.sv =====
// ----------------------------------------------------------------------------
// q2e_checker
// port-level checks for quaternion_to_euler
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module q2e_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_yaw,
   input logic [15:0] rsp_pitch,
   input logic [15:0] rsp_roll,
   input logic        rsp_invalid
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped while stalled")
   `ASSERT_CLK(a_invalid_zero, clock, reset, rsp_valid && rsp_invalid |-> (rsp_yaw == '0) && (rsp_pitch == '0) && (rsp_roll == '0), "invalid item with nonzero angles")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")
   `ASSERT_CLK(a_flow, clock, reset, rsp_ready |-> req_ready, "input blocked while output drains")

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_yaw     (rsp.yaw_angle),
   .rsp_pitch   (rsp.pitch_angle),
   .rsp_roll    (rsp.roll_angle),
   .rsp_invalid (rsp.invalid)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// random and directed quaternions through quaternion_to_euler, with every
// result checked against a bit-exact cordic prediction in both angle units
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic signed [15:0] r;
      logic signed [15:0] i;
      logic signed [15:0] j;
      logic signed [15:0] k;
   } quat_type;

   typedef struct {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic               inv;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   q2e_req_if req ();
   q2e_rsp_if rsp ();

   quaternion_to_euler uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   logic   unit_deg = 1'b0;
   int     send_idle = 27;
   int     recv_idle = 62;
   logic   hold_request = 1'b0;
   logic   hold_used = 1'b0;
   int     hold_left = 0;
   int     errors = 0;
   logic   taken_last = 1'b0;

   function automatic longint atan_step(int n);
      if (n < 10) return longint'(q2e_pkg::ATAN_HEAD[n]);
      if (n < 30) return 64'sd1 <<< (29 - n);
      return 0;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd1686629713 : -64'sd1686629713;
         x = -x;
         y = -y;
      end
      x = x * (64'sd1 <<< 20);
      y = y * (64'sd1 <<< 20);
      for (int n = 0; n < q2e_pkg::CORDIC_STEPS && n < 32; n++) begin
         dx = y >>> n;
         dy = x >>> n;
         if (y < 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_step(n);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_step(n);
         end
      end
      return z;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, one;
      res = 0;
      one = 64'd1 << 62;
      while (one > v) one = one >> 2;
      while (one != 0) begin
         if (v >= res + one) begin
            v = v - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] scale_angle(longint a, logic deg);
      longint r;
      if (deg) r = (a * 64'sd961263669 + (64'sd1 <<< 46)) >>> 47;
      else r = (a + (64'sd1 <<< 16)) >>> 17;
      return r[15:0];
   endfunction

   function automatic euler_type euler_of(quat_type q, logic deg);
      longint qr, qi, qj, qk, sr, si, sj, sk, n, p, pa;
      longint unsigned un, tw;
      euler_type e;
      qr = q.r; qi = q.i; qj = q.j; qk = q.k;
      sr = qr * qr; si = qi * qi; sj = qj * qj; sk = qk * qk;
      n = sr + si + sj + sk;
      e = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
      if (n == 0) return e;
      e.inv = 1'b0;
      e.yaw = scale_angle(vector_angle(2 * (qi * qj + qk * qr), si - sj - sk + sr), deg);
      e.roll = scale_angle(vector_angle(2 * (qj * qk + qi * qr), -si - sj + sk + sr), deg);
      p = qj * qr - qi * qk;
      if (p == 0) begin
         pa = 0;
      end else begin
         un = n;
         tw = 2 * ((p < 0) ? -p : p);
         if (tw >= un) pa = (p > 0) ? 64'sd843314856 : -64'sd843314856;
         else pa = vector_angle(2 * p, longint'(int_sqrt((un - tw) * (un + tw))));
      end
      e.pitch = scale_angle(pa, deg);
      return e;
   endfunction

   function automatic quat_type make_quat(int kind);
      quat_type q;
      int a, b;
      q.r = 16'($urandom); q.i = 16'($urandom); q.j = 16'($urandom); q.k = 16'($urandom);
      a = $urandom_range(0, 16384);
      b = $urandom_range(0, 16384);
      case (kind)
         0: q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
         1: begin
            q.r = 16'(a); q.j = 16'($urandom_range(0, 1) ? a : -a);
            q.i = 16'(b); q.k = 16'($urandom_range(0, 1) ? b : -b);
         end
         2: begin
            q.r = 16'($signed($urandom_range(0, 8)) - 4);
            q.i = 16'($signed($urandom_range(0, 8)) - 4);
            q.j = 16'($signed($urandom_range(0, 8)) - 4);
            q.k = 16'($signed($urandom_range(0, 8)) - 4);
         end
         3: begin
            q.r = q.r >>> 2; q.i = q.i >>> 2; q.j = q.j >>> 2; q.k = q.k >>> 2;
         end
         4: begin
            q.i = '0; q.k = '0;
         end
         default: ;
      endcase
      return q;
   endfunction

   task automatic load_phase(logic with_directed, int count);
      if (with_directed) begin
         pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
         pending_quats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
         pending_quats.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
         pending_quats.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
         pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
         pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
         pending_quats.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
         pending_quats.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
         pending_quats.push_back('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
         pending_quats.push_back('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
         pending_quats.push_back('{16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
         pending_quats.push_back('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
         pending_quats.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
         pending_quats.push_back('{16'sd0, -16'sd1, 16'sd0, 16'sd0});
         pending_quats.push_back('{16'sd100, 16'sd3, 16'sd99, -16'sd2});
         pending_quats.push_back('{-16'sd5000, 16'sd7000, 16'sd0, 16'sd0});
      end
      for (int n = 0; n < count; n++) pending_quats.push_back(make_quat($urandom_range(0, 9)));
   endtask

   task automatic drain_and_set_unit(logic deg);
      while (pending_quats.size() != 0 || expected_angles.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= deg;
      @(posedge clock);
      unit_deg = deg;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      load_phase(1'b1, 90);
      drain_and_set_unit(1'b1);
      send_idle = 62; recv_idle = 27;
      load_phase(1'b1, 90);
      drain_and_set_unit(1'b0);
      send_idle = 0; recv_idle = 0;
      load_phase(1'b0, 90);
      drain_and_set_unit(1'b1);
      hold_request = 1'b1;
      load_phase(1'b0, 90);
      while (pending_quats.size() != 0 || expected_angles.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("testbench NOT OK");
      $finish;
   end

   // accepted items become expected angle sets
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         expected_angles.push_back(euler_of(pending_quats[0], unit_deg));
         void'(pending_quats.pop_front());
      end
   end

   always @(posedge clock) taken_last <= !reset && req.valid && req.ready;

   // driver: hold an offered item until taken
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.q_real <= '0;
         req.q_i <= '0;
         req.q_j <= '0;
         req.q_k <= '0;
      end else if (!req.valid || taken_last) begin
         if (pending_quats.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            req.valid <= 1'b1;
            req.q_real <= pending_quats[0].r;
            req.q_i <= pending_quats[0].i;
            req.q_j <= pending_quats[0].j;
            req.q_k <= pending_quats[0].k;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // long receiver stall, counted in cycles
   always @(negedge clock) begin
      if (hold_request && !hold_used) begin
         hold_left = 300;
         hold_used = 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      euler_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_angles.size() == 0) begin
            $display("%0t: unexpected item yaw %0d pitch %0d roll %0d invalid %0b", $time,
                     rsp.yaw_angle, rsp.pitch_angle, rsp.roll_angle, rsp.invalid);
            errors++;
         end else begin
            e = expected_angles.pop_front();
            if (rsp.yaw_angle !== e.yaw || rsp.pitch_angle !== e.pitch ||
                rsp.roll_angle !== e.roll || rsp.invalid !== e.inv) begin
               $display("%0t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b", $time,
                        e.yaw, e.pitch, e.roll, e.inv, rsp.yaw_angle, rsp.pitch_angle,
                        rsp.roll_angle, rsp.invalid);
               errors++;
            end
         end
      end
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_if.sv
rtl/q2e_cordic.sv
rtl/quaternion_to_euler.sv
rtl/q2e_checker.sv
sim/testbench.sv
